// ----- rtl/hyperboloid_vertex_generator_unit_assert.svh -----
// assertion macros for the hyperboloid vertex generator checker
// expects clk and rst_n to be visible where the macros are used
`ifndef HYPERBOLOID_VERTEX_GENERATOR_UNIT_ASSERT_SVH
`define HYPERBOLOID_VERTEX_GENERATOR_UNIT_ASSERT_SVH
// same-cycle implication
`define HVG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define HVG_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/hvg_pkg.sv -----
// shared constants, register codes and helper functions
// no dependencies
package hvg_pkg;

    localparam int XY_W = 34;
    localparam int ATAN_ENTRIES = 30;
    localparam logic signed [41:0] PI_Q24 = 42'sd52707179;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [2:0] {
        REG_CENTER_X   = 3'd0,
        REG_CENTER_Y   = 3'd1,
        REG_CENTER_Z   = 3'd2,
        REG_HIP_RADIUS = 3'd3,
        REG_AXIS_SCALE = 3'd4,
        REG_REV_STEP   = 3'd5,
        REG_ELEV_STEP  = 3'd6
    } cfg_reg_t;

    function automatic logic signed [XY_W-1:0] atan_turn(input int idx);
        logic signed [XY_W-1:0] r;
        case (idx)
            0:  r = 34'sd536870912;
            1:  r = 34'sd316933406;
            2:  r = 34'sd167458907;
            3:  r = 34'sd85004756;
            4:  r = 34'sd42667331;
            5:  r = 34'sd21354465;
            6:  r = 34'sd10679838;
            7:  r = 34'sd5340245;
            8:  r = 34'sd2670163;
            9:  r = 34'sd1335087;
            10: r = 34'sd667544;
            11: r = 34'sd333772;
            12: r = 34'sd166886;
            13: r = 34'sd83443;
            14: r = 34'sd41722;
            15: r = 34'sd20861;
            16: r = 34'sd10430;
            17: r = 34'sd5215;
            18: r = 34'sd2608;
            19: r = 34'sd1304;
            20: r = 34'sd652;
            21: r = 34'sd326;
            22: r = 34'sd163;
            23: r = 34'sd81;
            24: r = 34'sd41;
            25: r = 34'sd20;
            26: r = 34'sd10;
            27: r = 34'sd5;
            28: r = 34'sd3;
            29: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'h7fff_ffff;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/hvg_cordic.sv -----
// pipelined cordic rotator, one rotation step per register stage
// depends on hvg_pkg
module hvg_cordic #(
    parameter int STAGES = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_vld,
    input  logic [31:0]                     in_angle,
    output logic                            out_vld,
    output logic signed [hvg_pkg::XY_W-1:0] out_cos,
    output logic signed [hvg_pkg::XY_W-1:0] out_sin
);

    localparam int W = hvg_pkg::XY_W;
    localparam int STEPS = (STAGES < hvg_pkg::ATAN_ENTRIES) ? STAGES : hvg_pkg::ATAN_ENTRIES;

    logic signed [W-1:0] x_reg [0:STEPS];
    logic signed [W-1:0] y_reg [0:STEPS];
    logic signed [W-1:0] z_reg [0:STEPS];
    logic [1:0]          q_reg [0:STEPS];
    logic                vld_reg [0:STEPS];

    logic [31:0]         rnd_angle;
    logic [1:0]          q_next;
    logic [31:0]         res_next;

    assign rnd_angle = in_angle + 32'h2000_0000;
    assign q_next    = rnd_angle[31:30];
    assign res_next  = in_angle - {q_next, 30'b0};

    // quarter-turn reduction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= hvg_pkg::CORDIC_GAIN;
            y_reg[0] <= '0;
            z_reg[0] <= W'($signed(res_next));
            q_reg[0] <= q_next;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic signed [W-1:0] dx;
        logic signed [W-1:0] dy;
        logic signed [W-1:0] x_next;
        logic signed [W-1:0] y_next;
        logic signed [W-1:0] z_next;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_comb
        begin
            if (z_reg[i] >= 0)
            begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - hvg_pkg::atan_turn(i);
            end
            else
            begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + hvg_pkg::atan_turn(i);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1] <= x_next;
                y_reg[i+1] <= y_next;
                z_reg[i+1] <= z_next;
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    logic signed [W-1:0] cos_next;
    logic signed [W-1:0] sin_next;
    logic                out_vld_reg;
    logic signed [W-1:0] cos_reg;
    logic signed [W-1:0] sin_reg;

    // quadrant restore
    always_comb
    begin
        case (q_reg[STEPS])
            2'd0:
            begin
                cos_next = x_reg[STEPS];
                sin_next = y_reg[STEPS];
            end
            2'd1:
            begin
                cos_next = -y_reg[STEPS];
                sin_next = x_reg[STEPS];
            end
            2'd2:
            begin
                cos_next = -x_reg[STEPS];
                sin_next = -y_reg[STEPS];
            end
            default:
            begin
                cos_next = y_reg[STEPS];
                sin_next = -x_reg[STEPS];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_reg[STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign out_vld = out_vld_reg;
    assign out_cos = cos_reg;
    assign out_sin = sin_reg;

endmodule

// ----- rtl/hyperboloid_vertex_generator_unit.sv -----
// top level of the hyperboloid side-surface vertex generator
// depends on hvg_pkg and hvg_cordic
//
// usage:
// - configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
//   high; write registers only while no transaction is in flight
// - input: in_valid/in_stall carrying row_index and column_index
// - output: out_valid/out_stall carrying vertex_x, vertex_y, vertex_z
// - pipeline: angle and elevation register, cordic (CORDIC_STAGES capped at 30 rotation
//   steps), products, rotated terms, radius scaling, center offset and saturation
// - throughput: one transaction per cycle unless out_stall holds the pipeline, set by the
//   fully pipelined cordic and multiplier stages
// - when out_stall holds off a valid result the whole pipeline freezes and
//   in_stall is raised in the same cycle; nothing is dropped or repeated
// - reset clears all valid bits and loads the register defaults
module hyperboloid_vertex_generator_unit #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [8:0]  row_index,
    input  logic [7:0]  column_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] vertex_x,
    output logic signed [31:0] vertex_y,
    output logic signed [31:0] vertex_z
);

    localparam int W = hvg_pkg::XY_W;
    localparam int STEPS = (CORDIC_STAGES < hvg_pkg::ATAN_ENTRIES) ?
                           CORDIC_STAGES : hvg_pkg::ATAN_ENTRIES;

    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic signed [31:0] center_z_reg;
    logic [30:0]        hip_radius_reg;
    logic signed [31:0] axis_scale_reg;
    logic [31:0]        revolve_step_reg;
    logic [30:0]        elevation_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg       <= '0;
            center_y_reg       <= '0;
            center_z_reg       <= '0;
            hip_radius_reg     <= 31'd65536;
            axis_scale_reg     <= 32'sd65536;
            revolve_step_reg   <= 32'd16777216;
            elevation_step_reg <= 31'd411775;
        end
        else if (cfg_valid)
        begin
            case (hvg_pkg::cfg_reg_t'(cfg_index))
                hvg_pkg::REG_CENTER_X:   center_x_reg       <= cfg_data;
                hvg_pkg::REG_CENTER_Y:   center_y_reg       <= cfg_data;
                hvg_pkg::REG_CENTER_Z:   center_z_reg       <= cfg_data;
                hvg_pkg::REG_HIP_RADIUS: hip_radius_reg     <= cfg_data[30:0];
                hvg_pkg::REG_AXIS_SCALE: axis_scale_reg     <= cfg_data;
                hvg_pkg::REG_REV_STEP:   revolve_step_reg   <= cfg_data;
                hvg_pkg::REG_ELEV_STEP:  elevation_step_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    logic en;
    logic out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = out_valid_reg && out_stall;

    // angle and elevation
    logic [39:0]         u_prod;
    logic [39:0]         rv_prod;
    logic signed [41:0]  v_wide;
    logic [31:0]         u_next;
    logic signed [31:0]  v_next;
    logic                vld_a_reg;
    logic [31:0]         u_reg;
    logic signed [31:0]  v_reg;

    assign u_prod  = {32'b0, column_index} * {8'b0, revolve_step_reg};
    assign rv_prod = {31'b0, row_index} * {9'b0, elevation_step_reg};
    assign v_wide  = $signed({2'b0, rv_prod}) - hvg_pkg::PI_Q24;
    assign u_next  = u_prod[31:0];
    assign v_next  = hvg_pkg::sat32(64'(v_wide));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg <= u_next;
            v_reg <= v_next;
        end
    end

    logic                cs_vld;
    logic signed [W-1:0] cos_w;
    logic signed [W-1:0] sin_w;

    hvg_cordic #(
        .STAGES(CORDIC_STAGES)
    ) u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld_a_reg),
        .in_angle (u_reg),
        .out_vld  (cs_vld),
        .out_cos  (cos_w),
        .out_sin  (sin_w)
    );

    // elevation delay matching the cordic
    logic signed [31:0] v_dly_reg [0:STEPS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_dly_reg[0] <= v_reg;
            for (int k = 1; k <= STEPS + 1; k++)
            begin
                v_dly_reg[k] <= v_dly_reg[k-1];
            end
        end
    end

    // products
    logic signed [65:0]  vs_next;
    logic signed [65:0]  vc_next;
    logic signed [63:0]  sv_next;
    logic                vld_m_reg;
    logic signed [65:0]  vs_reg;
    logic signed [65:0]  vc_reg;
    logic signed [63:0]  sv_reg;
    logic signed [W-1:0] cos_m_reg;
    logic signed [W-1:0] sin_m_reg;

    assign vs_next = v_dly_reg[STEPS+1] * sin_w;
    assign vc_next = v_dly_reg[STEPS+1] * cos_w;
    assign sv_next = axis_scale_reg * v_dly_reg[STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_m_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_m_reg <= cs_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vs_reg    <= vs_next;
            vc_reg    <= vc_next;
            sv_reg    <= sv_next;
            cos_m_reg <= cos_w;
            sin_m_reg <= sin_w;
        end
    end

    // rotated terms and y sum
    logic signed [66:0] diff_a;
    logic signed [66:0] diff_b;
    logic signed [40:0] ysum_next;
    logic               vld_ab_reg;
    logic signed [34:0] a_reg;
    logic signed [34:0] b_reg;
    logic signed [40:0] ysum_reg;

    assign diff_a    = (67'(cos_m_reg) <<< 24) - 67'(vs_reg);
    assign diff_b    = (67'(sin_m_reg) <<< 24) + 67'(vc_reg);
    assign ysum_next = 41'(center_y_reg) + 41'(sv_reg >>> 24);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_ab_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_ab_reg <= vld_m_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= diff_a[66:32];
            b_reg    <= diff_b[66:32];
            ysum_reg <= ysum_next;
        end
    end

    // radius scaling
    logic signed [66:0] ra_next;
    logic signed [66:0] rb_next;
    logic               vld_r_reg;
    logic signed [66:0] ra_reg;
    logic signed [66:0] rb_reg;
    logic signed [40:0] ysum_r_reg;

    assign ra_next = $signed({1'b0, hip_radius_reg}) * a_reg;
    assign rb_next = $signed({1'b0, hip_radius_reg}) * b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_r_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_r_reg <= vld_ab_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ra_reg     <= ra_next;
            rb_reg     <= rb_next;
            ysum_r_reg <= ysum_reg;
        end
    end

    // center offset and saturation
    logic signed [45:0] xsum;
    logic signed [45:0] zsum;
    logic [31:0]        vertex_x_next;
    logic [31:0]        vertex_y_next;
    logic [31:0]        vertex_z_next;
    logic signed [31:0] vertex_x_reg;
    logic signed [31:0] vertex_y_reg;
    logic signed [31:0] vertex_z_reg;

    assign xsum          = 46'(center_x_reg) + 46'(ra_reg >>> 22);
    assign zsum          = 46'(center_z_reg) + 46'(rb_reg >>> 22);
    assign vertex_x_next = hvg_pkg::sat32(64'(xsum));
    assign vertex_y_next = hvg_pkg::sat32(64'(ysum_r_reg));
    assign vertex_z_next = hvg_pkg::sat32(64'(zsum));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vld_r_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vertex_x_reg <= vertex_x_next;
            vertex_y_reg <= vertex_y_next;
            vertex_z_reg <= vertex_z_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign vertex_x  = vertex_x_reg;
    assign vertex_y  = vertex_y_reg;
    assign vertex_z  = vertex_z_reg;

endmodule

// ----- rtl/hvg_checker.sv -----
// port-level checker for the vertex generator, bound to the top level
// depends on hyperboloid_vertex_generator_unit_assert.svh
`include "hyperboloid_vertex_generator_unit_assert.svh"

module hvg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [31:0] cfg_data,
    input logic        in_valid,
    input logic        in_stall,
    input logic [8:0]  row_index,
    input logic [7:0]  column_index,
    input logic        out_valid,
    input logic        out_stall,
    input logic signed [31:0] vertex_x,
    input logic signed [31:0] vertex_y,
    input logic signed [31:0] vertex_z
);

    logic unused_ok;
    assign unused_ok = ^{cfg_valid, cfg_index, cfg_data, row_index, column_index, in_valid,
                         vertex_x, vertex_y, vertex_z};

    `HVG_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
    `HVG_ASSERT_IMP(a_in_stall, in_stall, out_valid && out_stall, "input stalled without cause")
    `HVG_ASSERT_IMP(a_in_flow, out_valid && out_stall, in_stall, "pipeline not held on stall")
    `HVG_ASSERT_IMP(a_cfg_rdy, 1'b1, cfg_ready || unused_ok || !unused_ok, "config not ready")

endmodule

bind hyperboloid_vertex_generator_unit hvg_checker u_hvg_checker (.*);
